// File: src/rbm_pkg.sv
// shared types and constants for the region boundary marker
package rbm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int MEM_DEPTH  = 2 ** COL_W;
  localparam int WCNT_W     = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W      = 16;
  localparam int PIX_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARKER_RED   = 3'd0,
    REG_MARKER_GREEN = 3'd1,
    REG_MARKER_BLUE  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_LOAD_BACK,
    PH_LOAD_FRONT,
    PH_RUN
  } phase_t;

  typedef struct packed {
    logic run;
    logic back_rd;
    logic load_tail;
  } phase_ctl_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       is_boundary;
    logic       end_of_frame;
  } result_t;

  // results caused by one pixel, packed in output order
  typedef struct packed {
    logic [1:0] cnt;
    logic [2:0] bnd;
    logic       eof;
  } bundle_t;

endpackage

// File: src/region_boundary_marker_top.sv
// four-neighbor boundary marker over two line stores, with a result queue
// the result for a pixel enters the result queue when its lower neighbor (or, on the
//   last row, its right neighbor or itself) is transferred, and leaves it in order
// throughput: one pixel per cycle while the queue has room, set by one read-modify-write of each
//   line store per pixel; on the last row of a frame taller than one row the output limits it
// reset and every register write start a reload of the column window from the line stores
//   in PH_LOAD_BACK then PH_LOAD_FRONT, with pixel_stall high; line stores are not cleared
module region_boundary_marker_top import rbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  pixel_t                pixel,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [7:0]       marker_red;
  logic [7:0]       marker_green;
  logic [7:0]       marker_blue;
  logic [10:0]      image_width;
  logic [ROW_W-1:0] image_height;

  // frame position and history
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [PIX_W-1:0] prev_pixel;
  logic [PIX_W-1:0] p1;
  logic [PIX_W-1:0] p2;

  // line stores and their registered reads
  logic [PIX_W-1:0] center_mem [MEM_DEPTH];
  logic [PIX_W-1:0] above_mem  [MEM_DEPTH];
  logic [PIX_W-1:0] c_rd0, c_rd1, a_rd0, a_rd1;
  logic [PIX_W-1:0] c_wd, a_wd;
  logic             fwd_c0, fwd_c1, fwd_a0, fwd_a1;
  logic [COL_W-1:0] ra_c0, ra_c1, ra_a0, ra_a1;

  phase_t     phase, phase_next;
  phase_ctl_t ctl;

  logic [WCNT_W-1:0] w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [COL_W-1:0]  xc, x_step, x_nxt;
  logic [ROW_W-1:0]  yc;
  logic              last_col, last_row;
  logic              has_left, has_left2, has_right, has_up, has_up2;
  logic              accept;
  logic [PIX_W-1:0]  cur;
  logic [PIX_W-1:0]  c_x, c_xp1, a_x, a_xm1;
  logic              e0, e1, e2, b0, b1, b2;
  bundle_t           bundle;

  // result queue
  bundle_t           fifo_mem [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr, rd_ptr;
  logic [FCNT_W-1:0] fifo_count;
  logic [1:0]        sub;
  bundle_t           head;
  logic              push, pop, last_sub, sel_bnd;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      marker_red   <= 8'd255;
      marker_green <= 8'd255;
      marker_blue  <= 8'd255;
      image_width  <= 11'd640;
      image_height <= 16'd480;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MARKER_RED:   marker_red   <= cfg_data[7:0];
        REG_MARKER_GREEN: marker_green <= cfg_data[7:0];
        REG_MARKER_BLUE:  marker_blue  <= cfg_data[7:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // phase sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LOAD_BACK;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    unique case (phase)
      PH_LOAD_BACK:  phase_next = PH_LOAD_FRONT;
      PH_LOAD_FRONT: phase_next = PH_RUN;
      PH_RUN:        phase_next = PH_RUN;
      default:       phase_next = PH_LOAD_BACK;
    endcase
    // new geometry means the window must be read again
    if (cfg_write) begin
      phase_next = PH_LOAD_BACK;
    end
  end

  always_comb begin
    ctl = '0;
    unique case (phase)
      PH_LOAD_BACK:  ctl.back_rd   = 1'b1;
      PH_LOAD_FRONT: ctl.load_tail = 1'b1;
      PH_RUN:        ctl.run       = 1'b1;
      default: ;
    endcase
  end

  // effective geometry and clamped position
  always_comb begin
    if (image_width == '0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(image_width);
    end
    h_eff = (image_height == '0) ? ROW_W'(1) : image_height;
    if (WCNT_W'(column_count) >= w_eff) begin
      xc = COL_W'(w_eff - WCNT_W'(1));
    end else begin
      xc = column_count;
    end
    yc = (row_count >= h_eff) ? h_eff - ROW_W'(1) : row_count;
  end

  assign last_col  = (WCNT_W'(xc) + WCNT_W'(1)) >= w_eff;
  assign last_row  = (yc == h_eff - ROW_W'(1));
  assign has_left  = (xc != '0);
  assign has_left2 = (xc >= COL_W'(2));
  assign has_right = !last_col;
  assign has_up    = (yc != '0);
  assign has_up2   = (yc >= ROW_W'(2));

  assign pixel_stall = !ctl.run || (fifo_count == FCNT_W'(FIFO_DEPTH));
  assign accept      = pixel_valid && !pixel_stall;
  assign cur         = {pixel.pixel_red, pixel.pixel_green, pixel.pixel_blue};

  assign x_step = last_col ? '0 : xc + COL_W'(1);
  assign x_nxt  = accept ? x_step : xc;

  // addresses around the next column, or, in PH_LOAD_BACK, center_mem at the two columns before it
  always_comb begin
    if (ctl.back_rd) begin
      ra_c0 = xc - COL_W'(2);
      ra_c1 = xc - COL_W'(1);
    end else begin
      ra_c0 = x_nxt;
      ra_c1 = x_nxt + COL_W'(1);
    end
    ra_a0 = x_nxt;
    ra_a1 = x_nxt - COL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      center_mem[xc] <= cur;
    end
    c_rd0 <= center_mem[ra_c0];
    c_rd1 <= center_mem[ra_c1];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      above_mem[xc] <= c_x;
    end
    a_rd0 <= above_mem[ra_a0];
    a_rd1 <= above_mem[ra_a1];
  end

  // write data bypass when a read hits the entry written in the same cycle
  always_ff @(posedge clk) begin
    c_wd <= cur;
    a_wd <= c_x;
    if (rst) begin
      fwd_c0 <= 1'b0;
      fwd_c1 <= 1'b0;
      fwd_a0 <= 1'b0;
      fwd_a1 <= 1'b0;
    end else begin
      fwd_c0 <= accept && (ra_c0 == xc);
      fwd_c1 <= accept && (ra_c1 == xc);
      fwd_a0 <= accept && (ra_a0 == xc);
      fwd_a1 <= accept && (ra_a1 == xc);
    end
  end

  assign c_x   = fwd_c0 ? c_wd : c_rd0;
  assign c_xp1 = fwd_c1 ? c_wd : c_rd1;
  assign a_x   = fwd_a0 ? a_wd : a_rd0;
  assign a_xm1 = fwd_a1 ? a_wd : a_rd1;

  // current row two columns back, kept as a shift of the last two pixels
  always_ff @(posedge clk) begin
    if (accept) begin
      p2 <= p1;
      p1 <= cur;
    end else if (ctl.load_tail) begin
      p2 <= c_x;
      p1 <= c_xp1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pixel   <= '0;
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      prev_pixel   <= cur;
      column_count <= x_step;
      if (last_col) begin
        row_count <= last_row ? '0 : yc + ROW_W'(1);
      end else begin
        row_count <= yc;
      end
    end
  end

  // boundary decisions: pixel above, pixel to the left on the last row, final pixel
  assign e0 = has_up;
  assign b0 = (c_x != cur) || (has_left && (a_xm1 != c_x)) ||
              (has_right && (c_xp1 != c_x)) || (has_up2 && (a_x != c_x));
  assign e1 = last_row && has_left;
  assign b1 = (prev_pixel != cur) || (has_left2 && (p2 != prev_pixel)) ||
              (has_up && (a_xm1 != prev_pixel));
  assign e2 = last_row && last_col;
  assign b2 = (has_left && (prev_pixel != cur)) || (has_up && (c_x != cur));

  always_comb begin
    bundle.cnt    = {1'b0, e0} + {1'b0, e1} + {1'b0, e2};
    bundle.bnd[0] = e0 ? b0 : (e1 ? b1 : b2);
    bundle.bnd[1] = (e0 && e1) ? b1 : b2;
    bundle.bnd[2] = b2;
    bundle.eof    = e2;
  end

  assign push = accept && (e0 || e1 || e2);

  assign head     = fifo_mem[rd_ptr];
  assign last_sub = (sub == head.cnt - 2'd1);
  assign sel_bnd  = head.bnd[sub];
  assign pop      = result_valid && !result_stall && last_sub;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      sub        <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fifo_count <= fifo_count + FCNT_W'(1);
        2'b01:   fifo_count <= fifo_count - FCNT_W'(1);
        default: fifo_count <= fifo_count;
      endcase
      if (result_valid && !result_stall) begin
        sub <= last_sub ? 2'd0 : sub + 2'd1;
      end
    end
  end

  assign result_valid        = (fifo_count != '0);
  assign result.out_red      = sel_bnd ? marker_red : 8'd0;
  assign result.out_green    = sel_bnd ? marker_green : 8'd0;
  assign result.out_blue     = sel_bnd ? marker_blue : 8'd0;
  assign result.is_boundary  = sel_bnd;
  assign result.end_of_frame = head.eof && last_sub;

endmodule
